/* design/cartridge_bank_address_mapper_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank address mapper
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_ADDRESS_MAPPER_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_ADDRESS_MAPPER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// check a property on every clock edge outside of reset
`define CBAM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check a property on every clock edge, reset included
`define CBAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CBAM_ASSERT(lbl, clk, rstn, prop, msg)
`define CBAM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* design/cbam_pkg.sv */
// ----------------------------------------------------------------------------
// cbam_pkg
// Shared widths, codes and constants of the cartridge bank address mapper.
// ----------------------------------------------------------------------------
package cbam_pkg;

  // default depth of the battery save RAM, as log2 of its byte count
  localparam int unsigned SramAddrBitsDefault = 17;

  // payload widths
  localparam int unsigned AddrW   = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TargetW = 2;
  localparam int unsigned RomOffW = 23;
  localparam int unsigned LayoutW = 3;
  localparam int unsigned SBitsW  = 5;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;
  localparam logic [CfgIdxW-1:0] CFG_LAYOUT    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_SRAM_BITS = 1'd1;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // result targets
  localparam logic [TargetW-1:0] TGT_NONE = 2'd0;
  localparam logic [TargetW-1:0] TGT_ROM  = 2'd1;
  localparam logic [TargetW-1:0] TGT_SRAM = 2'd2;
  localparam logic [TargetW-1:0] TGT_OPEN = 2'd3;

  // cartridge layouts
  localparam logic [LayoutW-1:0] LAY_LO      = 3'd0;
  localparam logic [LayoutW-1:0] LAY_HI      = 3'd1;
  localparam logic [LayoutW-1:0] LAY_EXLO    = 3'd2;
  localparam logic [LayoutW-1:0] LAY_EXHI    = 3'd3;
  localparam logic [LayoutW-1:0] LAY_SPLO    = 3'd4;
  localparam logic [LayoutW-1:0] LAY_LOMIR   = 3'd5;

  // ROM base offsets
  localparam logic [RomOffW-1:0] BASE_EXT   = 23'h400000;
  localparam logic [RomOffW-1:0] BASE_SP_80 = 23'h200000;
  localparam logic [RomOffW-1:0] BASE_SP_C0 = 23'h100000;

  typedef struct packed {
    logic                 opcode;
    logic [AddrW-1:0]     bus_address;
    logic [ByteW-1:0]     write_byte;
  } req_t;

  typedef struct packed {
    logic [TargetW-1:0]   target;
    logic [RomOffW-1:0]   rom_addr;
    logic [ByteW-1:0]     read_byte;
    logic                 variable_speed;
  } rsp_t;

endpackage

/* design/cbam_req_if.sv */
// ----------------------------------------------------------------------------
// cbam_req_if
// Bus access request channel: valid/ready handshake with access payload.
// ----------------------------------------------------------------------------
interface cbam_req_if;
  import cbam_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [AddrW-1:0]   bus_address;
  logic [ByteW-1:0]   write_byte;

  modport source (output valid, output opcode, output bus_address, output write_byte,
                  input ready);
  modport sink   (input valid, input opcode, input bus_address, input write_byte,
                  output ready);
endinterface

/* design/cbam_rsp_if.sv */
// ----------------------------------------------------------------------------
// cbam_rsp_if
// Decode result channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
interface cbam_rsp_if;
  import cbam_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TargetW-1:0]   target;
  logic [RomOffW-1:0]   rom_addr;
  logic [ByteW-1:0]     read_byte;
  logic                 variable_speed;

  modport source (output valid, output target, output rom_addr, output read_byte,
                  output variable_speed, input ready);
  modport sink   (input valid, input target, input rom_addr, input read_byte,
                  input variable_speed, output ready);
endinterface

/* design/cartridge_bank_address_mapper_core.sv */
// Cartridge bank address mapper. Each request is one 24-bit bus access that is
// decoded against the configured layout into not-cartridge, ROM (with a 23-bit
// ROM offset), battery SRAM or open bus, plus a timing flag. The battery SRAM
// lives in an internal single-port RAM of 2^SRAM_ADDR_BITS bytes with a
// registered read; that single port is the limit on rate: one request is
// accepted per cycle while the result side does not stall, and its result
// passes through stage 1 (decode and RAM access), then the output register.
// After reset the block zeroes the RAM, one byte per cycle, and takes no
// request until that pass is done; configuration writes are taken anytime
// but must only be made while no request is in flight.
// ----------------------------------------------------------------------------
// cartridge_bank_address_mapper_core
// Layout decode, save RAM and result register of the cartridge mapper.
// ----------------------------------------------------------------------------
module cartridge_bank_address_mapper_core #(
  parameter int unsigned SRAM_ADDR_BITS = cbam_pkg::SramAddrBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbam_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbam_pkg::CfgDataW-1:0] cfg_data_i,
  cbam_req_if.sink                      req_i,
  cbam_rsp_if.source                    rsp_o
);
  import cbam_pkg::*;

  `include "cartridge_bank_address_mapper_core_assert.svh"

  localparam int unsigned Depth = 2 ** SRAM_ADDR_BITS;

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  // configuration
  logic [LayoutW-1:0] layout_q;
  logic [SBitsW-1:0]  sbits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q <= LAY_LO;
      sbits_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LAYOUT:    layout_q <= cfg_data_i[LayoutW-1:0];
        CFG_SRAM_BITS: sbits_q  <= cfg_data_i[SBitsW-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic                      state_q, state_d;
  logic [SRAM_ADDR_BITS-1:0] clr_q, clr_d;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    if (state_q == ST_CLEAR) begin
      clr_d = clr_q + 1'b1;
      if (&clr_q) begin
        state_d = ST_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // pipeline control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_move;
  logic accept;

  assign s1_move     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = (state_q == ST_RUN) && (!s1_valid_q || s1_move);
  assign accept      = req_i.valid && req_i.ready;

  // decode
  logic [7:0]                bank;
  logic [6:0]                b7;
  logic [15:0]               lo16;
  logic [LayoutW-1:0]        lay;
  logic [SBitsW-1:0]         bits;
  logic                      have_sram;
  logic [SRAM_ADDR_BITS-1:0] mask;
  logic                      hi_bank;
  logic                      rom_from0;
  logic                      rom_ok;
  logic [RomOffW-1:0]        base;
  logic [RomOffW-1:0]        raw_off;
  logic                      sram_hit;
  logic [RomOffW-1:0]        sidx_full;
  logic [SRAM_ADDR_BITS-1:0] sidx;
  logic [TargetW-1:0]        dec_tgt;
  logic [RomOffW-1:0]        dec_roff;
  logic                      dec_var;
  logic                      is_wr;

  always_comb begin
    bank      = req_i.bus_address[23:16];
    b7        = bank[6:0];
    lo16      = req_i.bus_address[15:0];
    is_wr     = (req_i.opcode == OP_WRITE);
    lay       = (layout_q > LAY_LOMIR) ? LAY_LO : layout_q;
    bits      = (sbits_q > SBitsW'(SRAM_ADDR_BITS)) ? SBitsW'(SRAM_ADDR_BITS) : sbits_q;
    have_sram = (bits != '0);
    for (int i = 0; i < SRAM_ADDR_BITS; i++) begin
      mask[i] = (SBitsW'(i) < bits);
    end
    hi_bank   = bank[7];
    rom_from0 = 1'b0;
    rom_ok    = 1'b1;
    base      = '0;
    raw_off   = '0;
    sram_hit  = 1'b0;
    sidx_full = '0;
    dec_tgt   = TGT_NONE;
    dec_roff  = '0;
    dec_var   = 1'b0;

    if (bank == 8'h7E || bank == 8'h7F) begin
      // work RAM banks: not cartridge
    end else if (lay == LAY_HI || lay == LAY_EXHI) begin
      rom_from0 = (b7 inside {[7'h40:7'h7D]}) || (bank >= 8'hFE);
      base      = (lay == LAY_EXHI && bank < 8'hC0) ? BASE_EXT : '0;
      raw_off   = {1'b0, req_i.bus_address[21:0]};
      if (rom_from0 || lo16[15]) begin
        dec_var = hi_bank;
        if (is_wr) begin
          dec_tgt = TGT_OPEN;
        end else begin
          dec_tgt  = TGT_ROM;
          dec_roff = raw_off + base;
        end
      end
      if (have_sram && b7[6:5] == 2'b01 && lo16[15:13] == 3'b011) begin
        sram_hit  = 1'b1;
        sidx_full = {5'b0, req_i.bus_address[20:16], req_i.bus_address[12:0]};
        dec_var   = 1'b0;
      end
    end else begin
      raw_off = {1'b0, req_i.bus_address[22:16], req_i.bus_address[14:0]};
      if (lay == LAY_SPLO) begin
        if (bank < 8'h40 || (bank inside {[8'hA0:8'hBF]})) begin
          base = '0;
        end else if (bank inside {[8'h80:8'h9F]}) begin
          base = BASE_SP_80;
        end else if (bank inside {[8'hC0:8'hDF]}) begin
          rom_from0 = 1'b1;
          base      = BASE_SP_C0;
        end else begin
          rom_ok = 1'b0;
        end
      end else if (lay == LAY_EXLO && bank < 8'hC0) begin
        base = BASE_EXT;
      end
      if (rom_from0 || lo16[15]) begin
        dec_var = hi_bank;
        if (is_wr || !rom_ok) begin
          dec_tgt = TGT_OPEN;
        end else begin
          dec_tgt  = TGT_ROM;
          dec_roff = raw_off + base;
        end
      end
      if (have_sram && ((bank inside {[8'h70:8'h7D]}) || bank >= 8'hF0)
          && (lay == LAY_LOMIR || !lo16[15])) begin
        sram_hit  = 1'b1;
        sidx_full = {req_i.bus_address[23:16], req_i.bus_address[14:0]};
        dec_var   = (bank >= 8'hF0);
      end
    end

    sidx = sidx_full[SRAM_ADDR_BITS-1:0] & mask;
    if (sram_hit) begin
      dec_tgt  = TGT_SRAM;
      dec_roff = '0;
    end
    if (dec_tgt == TGT_NONE) begin
      dec_var = 1'b0;
    end
  end

  // save RAM: one port, the clearing pass owns it until done
  logic [ByteW-1:0]          mem [Depth];
  logic                      mem_we, mem_re;
  logic [SRAM_ADDR_BITS-1:0] mem_addr;
  logic [ByteW-1:0]          mem_wdata;
  logic [ByteW-1:0]          rdata_q;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_re    = 1'b0;
      mem_addr  = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = accept && sram_hit && is_wr;
      mem_re    = accept && sram_hit && !is_wr;
      mem_addr  = sidx;
      mem_wdata = req_i.write_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // stage 1: decoded request waiting for RAM data
  logic [TargetW-1:0] s1_tgt_q;
  logic [RomOffW-1:0] s1_roff_q;
  logic               s1_var_q;
  logic               s1_rd_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tgt_q  <= dec_tgt;
      s1_roff_q <= dec_roff;
      s1_var_q  <= dec_var;
      s1_rd_q   <= sram_hit && !is_wr;
    end
  end

  // output register
  rsp_t out_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.target         <= s1_tgt_q;
      out_q.rom_addr       <= s1_roff_q;
      out_q.read_byte      <= s1_rd_q ? rdata_q : '0;
      out_q.variable_speed <= s1_var_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.target         = out_q.target;
  assign rsp_o.rom_addr       = out_q.rom_addr;
  assign rsp_o.read_byte      = out_q.read_byte;
  assign rsp_o.variable_speed = out_q.variable_speed;

  `CBAM_ASSERT(a_no_req_in_clear, clk_i, rst_ni, (state_q == ST_CLEAR) |-> !req_i.ready, "request taken during clear")
  `CBAM_ASSERT_ALWAYS(a_ram_one_access, clk_i, !(mem_we && mem_re), "save RAM read and write in one cycle")
  `CBAM_ASSERT(a_rom_off_zero, clk_i, rst_ni, (out_valid_q && out_q.target != TGT_ROM) |-> (out_q.rom_addr == '0), "ROM offset set on non-ROM result")
  `CBAM_ASSERT(a_rbyte_sram, clk_i, rst_ni, (out_valid_q && out_q.read_byte != '0) |-> (out_q.target == TGT_SRAM), "read byte set on non-SRAM result")
  `CBAM_ASSERT(a_none_slow, clk_i, rst_ni, (out_valid_q && out_q.target == TGT_NONE) |-> !out_q.variable_speed, "speed flag set on non-cartridge result")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge mapper testbench
// Drives bus accesses through the request channel under a series of layout
// and save RAM size settings, predicts each decode result and the save RAM
// contents alongside the block, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import cbam_pkg::*;

  // no request is taken during the whole clearing pass after reset
  localparam int unsigned STALL_LIMIT  = 1 << 19;
  localparam int unsigned PHASES       = 16;
  localparam int unsigned PHASE_ITEMS  = 96;
  localparam int unsigned SAVE_BYTES   = 1 << SramAddrBitsDefault;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cbam_req_if req_if ();
  cbam_rsp_if rsp_if ();

  cartridge_bank_address_mapper_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // shadow of the block's registers and battery RAM
  logic [LayoutW-1:0] cur_layout;
  logic [SBitsW-1:0]  cur_sbits;
  logic [ByteW-1:0]   save_image [SAVE_BYTES];

  rsp_t        expected_results [$];
  logic [23:0] written_addrs [$];
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  bit          calm;

  logic [7:0]  corner_banks [22] = '{8'h00, 8'h1F, 8'h20, 8'h3F, 8'h40, 8'h6F, 8'h70,
                                     8'h7D, 8'h7E, 8'h7F, 8'h80, 8'h9F, 8'hA0, 8'hBF,
                                     8'hC0, 8'hDF, 8'hE0, 8'hEF, 8'hF0, 8'hFD, 8'hFE,
                                     8'hFF};
  logic [15:0] corner_offsets [8] = '{16'h0000, 16'h1FFF, 16'h5FFF, 16'h6000,
                                      16'h7FFF, 16'h8000, 16'hBFFF, 16'hFFFF};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Decode one access against the shadow layout; update the shadow RAM.
  function automatic rsp_t decode_access(logic op, logic [AddrW-1:0] addr,
                                         logic [ByteW-1:0] wb);
    int unsigned  a, bank, lo16, b7, bits, mask, lb, base, top, sidx;
    logic [2:0]   lay;
    bit           hit, rom;
    rsp_t         res;
    a    = 32'(addr);
    bank = a >> 16;
    lo16 = a & 'hFFFF;
    lay  = (cur_layout > LAY_LOMIR) ? LAY_LO : cur_layout;
    bits = (cur_sbits > SramAddrBitsDefault) ? SramAddrBitsDefault : cur_sbits;
    mask = (bits != 0) ? ((1 << bits) - 1) : 0;
    res  = '0;
    hit  = 1'b0;
    sidx = 0;
    if (bank == 'h7E || bank == 'h7F) begin
      // work RAM, never the cartridge
    end else if (lay == LAY_HI || lay == LAY_EXHI) begin
      b7 = bank & 'h7F;
      lb = ((b7 >= 'h40 && b7 <= 'h7D) || bank >= 'hFE) ? 0 : 'h8000;
      if (lo16 >= lb) begin
        res.variable_speed = (bank >= 'h80);
        if (op == OP_WRITE) begin
          res.target = TGT_OPEN;
        end else begin
          base = (lay == LAY_EXHI && bank < 'hC0) ? BASE_EXT : 0;
          res.target   = TGT_ROM;
          res.rom_addr = RomOffW'((a & 'h3FFFFF) + base);
        end
      end
      if (bits != 0 && b7 >= 'h20 && b7 <= 'h3F && lo16 >= 'h6000 && lo16 <= 'h7FFF) begin
        hit  = 1'b1;
        sidx = ((a & 'h1FFF) | ((a >> 3) & 'h3E000)) & mask;
        res.variable_speed = 1'b0;
      end
    end else begin
      lb   = 'h8000;
      base = 0;
      rom  = 1'b1;
      if (lay == LAY_SPLO) begin
        if (bank < 'h40 || (bank >= 'hA0 && bank <= 'hBF)) begin
          base = 0;
        end else if (bank >= 'h80 && bank <= 'h9F) begin
          base = BASE_SP_80;
        end else if (bank >= 'hC0 && bank <= 'hDF) begin
          lb   = 0;
          base = BASE_SP_C0;
        end else begin
          rom = 1'b0;
        end
      end else if (lay == LAY_EXLO && bank < 'hC0) begin
        base = BASE_EXT;
      end
      if (lo16 >= lb) begin
        res.variable_speed = (bank >= 'h80);
        if (op == OP_WRITE || !rom) begin
          res.target = TGT_OPEN;
        end else begin
          res.target   = TGT_ROM;
          res.rom_addr = RomOffW'(((a & 'h7FFF) | ((a >> 1) & 'h3F8000)) + base);
        end
      end
      if (bits != 0 && ((bank >= 'h70 && bank <= 'h7D) || bank >= 'hF0)) begin
        top = (lay == LAY_LOMIR) ? 'hFFFF : 'h7FFF;
        if (lo16 <= top) begin
          hit  = 1'b1;
          sidx = ((a & 'h7FFF) | ((a >> 1) & ~32'h7FFF)) & mask;
          res.variable_speed = (bank >= 'hF0);
        end
      end
    end
    if (hit) begin
      res.target   = TGT_SRAM;
      res.rom_addr = '0;
      if (op == OP_WRITE) save_image[sidx] = wb;
      else res.read_byte = save_image[sidx];
    end
    if (res.target == TGT_NONE) res.variable_speed = 1'b0;
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // response side: random backpressure, in-order checking, stall watchdog
  always @(posedge clk_i) begin
    rsp_if.ready <= calm || ($urandom_range(99) >= 23);
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, stall_cycles);
      $display("Test completed with failures");
      $finish;
    end else if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: target %0d rom_addr %0h",
                 $time, rsp_if.target, rsp_if.rom_addr);
      end else begin
        want = expected_results.pop_front();
        check_field("target", want.target, rsp_if.target);
        check_field("rom_addr", want.rom_addr, rsp_if.rom_addr);
        check_field("read_byte", want.read_byte, rsp_if.read_byte);
        check_field("variable_speed", want.variable_speed, rsp_if.variable_speed);
      end
    end
  end

  // Send one access; return right after the edge that takes it.
  task automatic send_access(logic op, logic [AddrW-1:0] addr, logic [ByteW-1:0] wb);
    while (!calm && $urandom_range(99) < 23) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.bus_address <= addr;
    req_if.write_byte  <= wb;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    expected_results.push_back(decode_access(op, addr, wb));
    if (op == OP_WRITE) begin
      written_addrs.push_back(addr);
      if (written_addrs.size() > 16) void'(written_addrs.pop_front());
    end
  endtask

  // Drop valid and hold until every outstanding result is back.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(logic [LayoutW-1:0] lay, logic [SBitsW-1:0] sbits);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LAYOUT;
    cfg_data_i <= CfgDataW'(lay);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SRAM_BITS;
    cfg_data_i <= CfgDataW'(sbits);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_layout = lay;
    cur_sbits  = sbits;
  endtask

  // After reset: lo layout with no save RAM.
  task automatic test_power_on_map();
    send_access(OP_READ,  24'h008000, 8'h00);
    send_access(OP_READ,  24'hFFFFFF, 8'hFF);
    send_access(OP_READ,  24'h7E1234, 8'h00);
    send_access(OP_READ,  24'h700000, 8'h00);
    send_access(OP_WRITE, 24'h008000, 8'hAA);
  endtask

  task automatic test_layout_corners();
    configure(LAY_LO, 5'd17);
    send_access(OP_WRITE, 24'h700000, 8'hA5);
    send_access(OP_READ,  24'h700000, 8'h00);
    send_access(OP_READ,  24'hF07FFF, 8'h00);
    configure(LAY_HI, 5'd17);
    send_access(OP_READ,  24'h400000, 8'h00);
    send_access(OP_WRITE, 24'h206000, 8'h5A);
    send_access(OP_READ,  24'h206000, 8'h00);
    configure(LAY_EXLO, 5'd17);
    send_access(OP_READ,  24'h008000, 8'h00);
    send_access(OP_READ,  24'hC08000, 8'h00);
    send_access(OP_WRITE, 24'h00FFFF, 8'h01);
    configure(LAY_EXHI, 5'd17);
    send_access(OP_READ,  24'h7DFFFF, 8'h00);
    send_access(OP_READ,  24'hC00000, 8'h00);
    send_access(OP_READ,  24'hFE0000, 8'h00);
    configure(LAY_SPLO, 5'd17);
    send_access(OP_READ,  24'h808000, 8'h00);
    send_access(OP_READ,  24'hC00000, 8'h00);
    send_access(OP_READ,  24'h408000, 8'h00);
    configure(LAY_LOMIR, 5'd17);
    send_access(OP_WRITE, 24'h70FFFF, 8'h3C);
    send_access(OP_READ,  24'h70FFFF, 8'h00);
    send_access(OP_READ,  24'h7D8000, 8'h00);
  endtask

  // Random accesses biased to bank and offset boundaries, with read-back of
  // recently written addresses, under a series of settings.
  task automatic test_random_phases();
    int unsigned       sbits_plan [8] = '{17, 0, 31, 1, 3, 17, 11, 5};
    logic [7:0]        bank;
    logic [15:0]       off;
    logic              op;
    logic [AddrW-1:0]  addr;
    for (int ph = 0; ph < PHASES; ph++) begin
      configure((ph < 8) ? LayoutW'(ph) : LayoutW'($urandom_range(7)),
                (ph < 8) ? SBitsW'(sbits_plan[ph]) : SBitsW'($urandom_range(31)));
      calm = (ph == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) wait_idle();
        if (written_addrs.size() != 0 && $urandom_range(99) < 20) begin
          op   = OP_READ;
          addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
        end else begin
          op   = 1'($urandom_range(1));
          bank = ($urandom_range(99) < 60) ? corner_banks[$urandom_range(21)]
                                           : 8'($urandom_range(255));
          case ($urandom_range(3))
            0: off = 16'($urandom_range(16'hFFFF));
            1: off = corner_offsets[$urandom_range(7)];
            2: off = 16'h6000 + 16'($urandom_range(16'h1FFF));
            default: off = 16'($urandom_range(16'h7FFF));
          endcase
          addr = {bank, off};
        end
        send_access(op, addr, 8'($urandom_range(255)));
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_LAYOUT;
    cfg_data_i         = '0;
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_READ;
    req_if.bus_address = '0;
    req_if.write_byte  = '0;
    cur_layout         = LAY_LO;
    cur_sbits          = '0;
    calm               = 1'b0;
    foreach (save_image[i]) save_image[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_power_on_map();
    test_layout_corners();
    test_random_phases();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
